[sv/infix_to_postfix_converter_macros.svh]
// Assertion macros for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Property must hold at every edge outside reset.
`define I2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define I2P_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[sv/i2p_pkg.sv]
// Types, character codes and helper functions for the infix to postfix converter.
package i2p_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } i2p_in_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic [1:0] status;
        logic       last;
    } i2p_out_t;

    // Sequencer to output stage
    typedef struct packed {
        logic     emit;     // new result into the holding slot
        logic     retire;   // push held result out, closing the item
        logic     last;     // last flag applied on retire
        i2p_out_t word;
    } i2p_req_t;

    // Output stage to sequencer
    typedef struct packed {
        logic pend_valid;
        logic blocked;      // holding slot full and output register busy
    } i2p_stat_t;

    localparam logic [1:0] STAT_SYMBOL           = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW         = 2'd1;
    localparam logic [1:0] STAT_UNMATCHED_CLOSE  = 2'd2;
    localparam logic [1:0] STAT_UNMATCHED_OPEN   = 2'd3;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;

    function automatic logic [2:0] prec(input logic [7:0] c);
        logic [2:0] p;
        if (c == CH_CARET) begin
            p = 3'd5;
        end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
            p = 3'd4;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 3'd3;
        end else begin
            p = 3'd2;
        end
        return p;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

endpackage

[sv/i2p_out_stage.sv]
// Result holding slot and output register of the infix to postfix converter.
module i2p_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  i2p_pkg::i2p_req_t  req,
    output i2p_pkg::i2p_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output i2p_pkg::i2p_out_t  m_data
);
    import i2p_pkg::*;

    logic     pend_valid_reg, pend_valid_next;
    i2p_out_t pend_reg, pend_next;
    logic     m_valid_reg, m_valid_next;
    i2p_out_t m_data_reg, m_data_next;
    logic     out_free;

    // The slot holds one result back so the last flag can be set once the item closes.
    assign out_free = !m_valid_reg || m_ready;
    assign stat     = '{pend_valid: pend_valid_reg, blocked: pend_valid_reg && !out_free};

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        if (req.emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = req.word;
        end else if (req.retire && pend_valid_reg) begin
            m_valid_next     = 1'b1;
            m_data_next      = pend_reg;
            m_data_next.last = req.last;
            pend_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/infix_to_postfix_converter.sv]
// Top level of the infix to postfix converter: sequencer and operator stack memory.
//
//  channel | direction | word                          | handshake
//  s_      | in        | symbol, end_of_expr           | s_valid / s_ready
//  m_      | out       | out_symbol, status, last      | m_valid / m_ready
//
// Sequence: one word in flight, pops paced by the stack memory's registered read. A letter,
// '(' or ')' on an empty stack is classified, then closed; other ')' pop entries, then
// take the '(' or the unmatched report; an operator pops, has a step where popping stops at
// a stacked entry, then pushes; an end word flushes each entry on the stack, then closes.
// Reset: aresetn synchronous, active low; clears the stack count and the sequencer.
// Stalls: a full output register with a held result freezes the sequencer in place.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2p_pkg::i2p_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i2p_pkg::i2p_out_t m_data
);
    import i2p_pkg::*;

    `include "infix_to_postfix_converter_macros.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);   // count, holds the depth itself
    localparam int AW = $clog2(STACK_DEPTH);       // stack address

    // Sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_POP       = 3'd1;   // top read back, pop or stop
    localparam logic [2:0] S_PUSH      = 3'd2;   // push the pending operator
    localparam logic [2:0] S_CLOSE_ERR = 3'd3;   // ')' ran the stack dry
    localparam logic [2:0] S_FINISH    = 3'd4;   // start flush or close the word
    localparam logic [2:0] S_FLUSH     = 3'd5;   // end-of-expression drain

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sym_reg, sym_next;
    logic          end_reg, end_next;
    logic          close_reg, close_next;    // pop loop driven by ')'

    // Stack memory, one write and one registered read per cycle
    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    rdata_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;

    i2p_req_t  req;
    i2p_stat_t stat;

    logic [CW-1:0] cnt_m1, cnt_m2;
    logic          full;
    logic          stop;
    logic [7:0]    top;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign full   = count_reg >= CW'(STACK_DEPTH);
    assign top    = rdata_reg;

    // Pop loop ends at '(' always; an operator also stops on lower precedence.
    assign stop = (top == CH_LPAREN) || (!close_reg && (prec(top) < prec(sym_reg)));

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sym_next   = sym_reg;
        end_next   = end_reg;
        close_next = close_reg;
        rd_en      = 1'b0;
        rd_addr    = cnt_m1[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = sym_reg;
        req        = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sym_next   = s_data.symbol;
                    end_next   = s_data.end_of_expr;
                    close_next = (s_data.symbol == CH_RPAREN);
                    state_next = S_FINISH;
                    if (s_data.symbol == CH_LPAREN) begin
                        if (!full) begin
                            wr_en      = 1'b1;
                            wr_data    = s_data.symbol;
                            count_next = count_reg + CW'(1);
                        end else begin
                            req.emit              = 1'b1;
                            req.word.status       = STAT_OVERFLOW;
                        end
                    end else if (is_letter(s_data.symbol)) begin
                        req.emit            = 1'b1;
                        req.word.out_symbol = s_data.symbol;
                        req.word.status     = STAT_SYMBOL;
                    end else if (count_reg != '0) begin
                        rd_en      = 1'b1;
                        state_next = S_POP;
                    end else if (s_data.symbol == CH_RPAREN) begin
                        req.emit        = 1'b1;
                        req.word.status = STAT_UNMATCHED_CLOSE;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_POP: begin
                if (stop) begin
                    if (close_reg) begin
                        count_next = cnt_m1;        // discard the matching '('
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_PUSH;
                    end
                end else if (!stat.blocked) begin
                    req.emit            = 1'b1;
                    req.word.out_symbol = top;
                    req.word.status     = STAT_SYMBOL;
                    count_next          = cnt_m1;
                    if (cnt_m1 != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m2[AW-1:0];
                    end else begin
                        state_next = close_reg ? S_CLOSE_ERR : S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!full) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_FINISH;
                end else if (!stat.blocked) begin
                    req.emit        = 1'b1;
                    req.word.status = STAT_OVERFLOW;
                    state_next      = S_FINISH;
                end
            end
            S_CLOSE_ERR: begin
                if (!stat.blocked) begin
                    req.emit        = 1'b1;
                    req.word.status = STAT_UNMATCHED_CLOSE;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (end_reg && count_reg != '0) begin
                    rd_en      = 1'b1;
                    state_next = S_FLUSH;
                end else if (!stat.blocked) begin
                    // held result is the word's final one
                    req.retire = 1'b1;
                    req.last   = end_reg;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!stat.blocked) begin
                    req.emit = 1'b1;
                    if (top == CH_LPAREN) begin
                        req.word.status = STAT_UNMATCHED_OPEN;
                    end else begin
                        req.word.out_symbol = top;
                        req.word.status     = STAT_SYMBOL;
                    end
                    count_next = cnt_m1;
                    if (cnt_m1 != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m2[AW-1:0];
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A push is always written into the memory before any read of that entry is issued, so no forwarding.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        sym_reg   <= sym_next;
        end_reg   <= end_next;
        close_reg <= close_next;
    end

    i2p_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `I2P_NEVER(a_count_in_range, count_reg > CW'(STACK_DEPTH), "stack count beyond depth")
    `I2P_NEVER(a_idle_slot_empty, state_reg == S_IDLE && stat.pend_valid, "result held while idle")
    `I2P_NEVER(a_no_emit_blocked, req.emit && stat.blocked, "result emitted into a blocked stage")
    `I2P_ASSERT(a_push_grows, wr_en |=> count_reg == $past(count_reg) + CW'(1), "push lost")

endmodule
